[src/fpe_pkg.sv]
// fpe_pkg: shared types and constants for the frame buffer pixel engine
// no dependencies; imported by the top level, its checker and the bench
package fpe_pkg;

  localparam int COORD_W    = 11;
  localparam int CUR_W      = COORD_W + 1;
  localparam int XRES_W     = 11;
  localparam int YRES_W     = 10;
  localparam int PIX_W      = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int CH_W       = 8;
  localparam int SUM_W      = 10;

  localparam logic [XRES_W-1:0] XRES_RST = 11'd1024;
  localparam logic [YRES_W-1:0] YRES_RST = 10'd768;

  localparam logic [PIX_W-1:0] TRANSPARENT_KEY = 24'hfffffe;

  // floor(s / 3) == (s * 683) >> 11 for every s below 2048
  localparam logic [SUM_W-1:0] GREY_RECIP = 10'd683;
  localparam int               GREY_SHIFT = 11;

  localparam logic [CFG_IDX_W-1:0] REG_XRES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_YRES = 1'b1;

  localparam logic [2:0] OP_PAINT  = 3'd0;
  localparam logic [2:0] OP_FILL   = 3'd1;
  localparam logic [2:0] OP_INVERT = 3'd2;
  localparam logic [2:0] OP_GREY   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_PAINT,
    ST_RD,
    ST_MOD,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic [PIX_W-1:0]   color;
  } in_item_t;

  typedef struct packed {
    logic             status;
    logic [PIX_W-1:0] pixel_value;
  } out_item_t;

endpackage

[src/fpe_ram.sv]
// fpe_ram: generic single-port synchronous ram with registered read
// no dependencies; holds the frame store of the pixel engine
module fpe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

[src/framebuffer_pixel_engine.sv]
// framebuffer_pixel_engine: 24-bit frame store engine; depends on fpe_pkg and fpe_ram
// each op is taken in idle and checked in calc; skipped or out-of-range ops then go to done,
// paint writes in its own state, invert, grey and read pass read then modify (invert and grey
// write back on the one ram port), and fill writes until complete or stopped at the edge
// next transaction accepted in the cycle out_valid rises; a stalled result delays that
// synchronous active-low reset clears control and resolution registers, not the frame store
module framebuffer_pixel_engine
  import fpe_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 768
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = ($clog2(MAX_WIDTH + 1) > XRES_W) ? $clog2(MAX_WIDTH + 1) : XRES_W;
  localparam int EH    = ($clog2(MAX_HEIGHT + 1) > YRES_W) ? $clog2(MAX_HEIGHT + 1) : YRES_W;
  localparam int CW0   = (EW > EH) ? EW : EH;
  localparam int CMP_W = (CW0 > CUR_W) ? CW0 : CUR_W;
  localparam int PRD_W = COORD_W + EW;
  localparam int GP_W  = 2 * SUM_W;

  state_t state_r, state_nxt;

  logic [XRES_W-1:0]  xres_r;
  logic [YRES_W-1:0]  yres_r;
  in_item_t           item_r, item_nxt;
  logic [CUR_W-1:0]   cur_x_r, cur_x_nxt;
  logic [CUR_W-1:0]   cur_y_r, cur_y_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [AW-1:0]      base_r, base_nxt;
  logic               status_r, status_nxt;
  logic [PIX_W-1:0]   pix_r, pix_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic [EW-1:0]      eff_w;
  logic [EH-1:0]      eff_h;
  logic [PRD_W-1:0]   prod;
  logic               pix_inb;
  logic               cur_inb;
  logic               transparent;
  logic               in_acc;
  logic               out_free;
  logic               last_col;
  logic               last_row;

  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [PIX_W-1:0]   mem_wdata;
  logic [PIX_W-1:0]   mem_rdata;

  logic [SUM_W-1:0]   grey_sum;
  logic [GP_W-1:0]    grey_prod;
  logic [CH_W-1:0]    grey_val;

  assign eff_w = (EW'(xres_r) > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(xres_r);
  assign eff_h = (EH'(yres_r) > EH'(MAX_HEIGHT)) ? EH'(MAX_HEIGHT) : EH'(yres_r);

  assign prod        = PRD_W'(item_r.y) * PRD_W'(eff_w);
  assign pix_inb     = (CMP_W'(item_r.x) < CMP_W'(eff_w)) && (CMP_W'(item_r.y) < CMP_W'(eff_h));
  assign cur_inb     = (CMP_W'(cur_x_r) < CMP_W'(eff_w)) && (CMP_W'(cur_y_r) < CMP_W'(eff_h));
  assign transparent = (item_r.color == TRANSPARENT_KEY);
  assign in_acc      = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign last_col    = (CUR_W'(col_r) + CUR_W'(1)) == CUR_W'(item_r.width);
  assign last_row    = (CUR_W'(row_r) + CUR_W'(1)) == CUR_W'(item_r.height);

  assign grey_sum  = SUM_W'(mem_rdata[23:16]) + SUM_W'(mem_rdata[15:8]) + SUM_W'(mem_rdata[7:0]);
  assign grey_prod = GP_W'(grey_sum) * GP_W'(GREY_RECIP);
  assign grey_val  = grey_prod[GREY_SHIFT +: CH_W];

  assign mem_addr = base_r + AW'(cur_x_r);

  fpe_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        unique case (item_r.op)
          OP_PAINT: begin
            state_nxt = (transparent || !pix_inb) ? ST_DONE : ST_PAINT;
          end
          OP_FILL: begin
            if (transparent || item_r.width == '0 || item_r.height == '0) begin
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_FILL;
            end
          end
          OP_INVERT, OP_GREY, OP_READ: begin
            state_nxt = pix_inb ? ST_RD : ST_DONE;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_PAINT: state_nxt = ST_DONE;
      ST_RD:    state_nxt = ST_MOD;
      ST_MOD:   state_nxt = ST_DONE;
      ST_FILL: begin
        if (!cur_inb || (last_col && last_row)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    item_nxt      = item_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    status_nxt    = status_r;
    pix_nxt       = pix_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_wdata     = item_r.color;
    in_stall      = (state_r != ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          item_nxt   = in_data;
          cur_x_nxt  = CUR_W'(in_data.x);
          cur_y_nxt  = CUR_W'(in_data.y);
          col_nxt    = '0;
          row_nxt    = '0;
          status_nxt = 1'b0;
          pix_nxt    = '0;
        end
      end
      ST_CALC: begin
        base_nxt = AW'(prod);
        if (!pix_inb && item_r.op != OP_FILL && !(item_r.op == OP_PAINT && transparent)) begin
          if (item_r.op == OP_PAINT || item_r.op == OP_INVERT || item_r.op == OP_GREY ||
              item_r.op == OP_READ) begin
            status_nxt = 1'b1;
          end
        end
      end
      ST_PAINT: begin
        mem_we = 1'b1;
      end
      ST_RD: begin
      end
      ST_MOD: begin
        unique case (item_r.op)
          OP_INVERT: begin
            mem_we    = 1'b1;
            mem_wdata = ~mem_rdata;
          end
          OP_GREY: begin
            mem_we    = 1'b1;
            mem_wdata = {grey_val, grey_val, grey_val};
          end
          default: begin
            pix_nxt = mem_rdata;
          end
        endcase
      end
      ST_FILL: begin
        if (!cur_inb) begin
          status_nxt = 1'b1;
        end else begin
          mem_we = 1'b1;
          if (last_col) begin
            col_nxt   = '0;
            row_nxt   = row_r + COORD_W'(1);
            cur_x_nxt = CUR_W'(item_r.x);
            cur_y_nxt = cur_y_r + CUR_W'(1);
            base_nxt  = base_r + AW'(eff_w);
          end else begin
            col_nxt   = col_r + COORD_W'(1);
            cur_x_nxt = cur_x_r + CUR_W'(1);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.status      = status_r;
          out_nxt.pixel_value = pix_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      xres_r      <= XRES_RST;
      yres_r      <= YRES_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_XRES: xres_r <= cfg_wdata[XRES_W-1:0];
          REG_YRES: yres_r <= cfg_wdata[YRES_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    cur_x_r  <= cur_x_nxt;
    cur_y_r  <= cur_y_nxt;
    col_r    <= col_nxt;
    row_r    <= row_nxt;
    base_r   <= base_nxt;
    status_r <= status_nxt;
    pix_r    <= pix_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[src/fpe_checker.sv]
// fpe_checker: port-level assertions for framebuffer_pixel_engine
// depends on fpe_pkg; attached to the top level by the bind at the end of this file
module fpe_checker
  import fpe_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // reset leaves no result pending and the input open
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result pending or input stalled after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an op is in progress");

  // no result can appear the cycle after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind framebuffer_pixel_engine fpe_checker u_fpe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[bench/framebuffer_pixel_engine_tb.sv]
// framebuffer_pixel_engine_tb: self-checking bench for the 24-bit frame store engine
// keeps its own copy of the frame store and resolution, predicts every reply, checks in order
// depends on fpe_pkg and the framebuffer_pixel_engine rtl
module framebuffer_pixel_engine_tb;
  import fpe_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 768;
  localparam int SETTLE = 12;
  localparam int COORD_MAX = 2**COORD_W - 1;
  localparam logic [2:0] OP_TOP = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  logic [PIX_W-1:0] frame_copy [int];
  int               written_addrs [$];
  out_item_t        reply_q [$];
  out_item_t        want;
  int               x_res;
  int               y_res;
  int               fail_count;
  int               stall_left;
  bit               no_idle;

  framebuffer_pixel_engine #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("status: fail");
    $finish;
  end

  function automatic int eff_w();
    return (x_res > MAX_W) ? MAX_W : x_res;
  endfunction

  function automatic int eff_h();
    return (y_res > MAX_H) ? MAX_H : y_res;
  endfunction

  function automatic bit on_screen(int px, int py);
    return px < eff_w() && py < eff_h();
  endfunction

  function automatic void put_pixel(int a, logic [PIX_W-1:0] v);
    if (!frame_copy.exists(a)) written_addrs.push_back(a);
    frame_copy[a] = v;
  endfunction

  function automatic void apply_pixel_op(in_item_t it);
    out_item_t        r;
    logic [PIX_W-1:0] p;
    logic [CH_W-1:0]  g8;
    int               a;
    int               chan_sum;
    bit               stop;
    r = '0;
    stop = 1'b0;
    a = int'(it.y) * eff_w() + int'(it.x);
    case (it.op)
      OP_PAINT: begin
        if (it.color != TRANSPARENT_KEY) begin
          if (!on_screen(int'(it.x), int'(it.y))) r.status = 1'b1;
          else put_pixel(a, it.color);
        end
      end
      OP_FILL: begin
        if (it.color != TRANSPARENT_KEY) begin
          for (int rr = 0; rr < int'(it.height) && !stop; rr++) begin
            for (int cc = 0; cc < int'(it.width); cc++) begin
              if (!on_screen(int'(it.x) + cc, int'(it.y) + rr)) begin
                stop = 1'b1;
                break;
              end
              put_pixel((int'(it.y) + rr) * eff_w() + int'(it.x) + cc, it.color);
            end
          end
          r.status = stop;
        end
      end
      OP_INVERT, OP_GREY, OP_READ: begin
        if (!on_screen(int'(it.x), int'(it.y))) begin
          r.status = 1'b1;
        end else begin
          p = frame_copy[a];
          if (it.op == OP_INVERT) begin
            put_pixel(a, ~p);
          end else if (it.op == OP_GREY) begin
            chan_sum = int'(p[23:16]) + int'(p[15:8]) + int'(p[7:0]);
            g8 = CH_W'(chan_sum / 3);
            put_pixel(a, {g8, g8, g8});
          end else begin
            r.pixel_value = p;
          end
        end
      end
      default: ;
    endcase
    reply_q.push_back(r);
  endfunction

  // find a written pixel that lies on screen under the current resolution
  function automatic bit pick_written(output logic [COORD_W-1:0] px,
                                      output logic [COORD_W-1:0] py);
    int ew;
    int area;
    int a;
    ew = eff_w();
    area = ew * eff_h();
    px = '0;
    py = '0;
    if (area == 0) return 1'b0;
    for (int t = 0; t < 8; t++) begin
      if (t[0] && written_addrs.size() > 0)
        a = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
      else
        a = $urandom_range(0, area - 1);
      if (a < area && frame_copy.exists(a)) begin
        px = COORD_W'(a % ew);
        py = COORD_W'(a / ew);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic in_item_t random_item();
    in_item_t           it;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    int                 ew;
    int                 eh;
    int                 sel;
    int                 shape;
    ew = eff_w();
    eh = eff_h();
    sel = $urandom_range(0, 99);
    it.width = COORD_W'($urandom);
    it.height = COORD_W'($urandom);
    it.color = ($urandom_range(0, 19) == 0) ? TRANSPARENT_KEY : PIX_W'($urandom);
    if (sel < 8) it.op = 3'($urandom_range(OP_READ + 1, OP_TOP));
    else if (sel < 38) it.op = OP_PAINT;
    else if (sel < 58) it.op = OP_FILL;
    else if (sel < 70) it.op = OP_INVERT;
    else if (sel < 82) it.op = OP_GREY;
    else it.op = OP_READ;
    if (ew > 0 && eh > 0 && $urandom_range(0, 99) < 85) begin
      it.x = COORD_W'($urandom_range(0, ew - 1));
      it.y = COORD_W'($urandom_range(0, eh - 1));
    end else if ($urandom_range(0, 1)) begin
      it.x = COORD_W'($urandom_range(ew, COORD_MAX));
      it.y = COORD_W'($urandom);
    end else begin
      it.x = COORD_W'($urandom);
      it.y = COORD_W'($urandom_range(eh, COORD_MAX));
    end
    if (it.op == OP_FILL) begin
      shape = $urandom_range(0, 15);
      if (shape == 0) begin
        it.width = COORD_W'($urandom);
        it.height = COORD_W'($urandom_range(0, 3));
      end else if (shape == 1) begin
        it.width = COORD_W'($urandom_range(0, 3));
        it.height = COORD_W'($urandom);
      end else begin
        it.width = COORD_W'($urandom_range(0, 8));
        it.height = COORD_W'($urandom_range(0, 8));
      end
    end else if ((it.op == OP_INVERT || it.op == OP_GREY || it.op == OP_READ)
                 && on_screen(int'(it.x), int'(it.y))) begin
      if (pick_written(px, py)) begin
        it.x = px;
        it.y = py;
      end else begin
        it.op = OP_PAINT;
      end
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_pixel_op(it);
  endtask

  task automatic send_op(logic [2:0] op, int px, int py, int w, int h,
                         logic [PIX_W-1:0] c);
    in_item_t it;
    it.op = op;
    it.x = COORD_W'(px);
    it.y = COORD_W'(py);
    it.width = COORD_W'(w);
    it.height = COORD_W'(h);
    it.color = c;
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_XRES) x_res = int'(val[XRES_W-1:0]);
    else y_res = int'(val[YRES_W-1:0]);
  endtask

  task automatic set_res(int xv, int yv);
    write_reg(REG_XRES, xv);
    write_reg(REG_YRES, yv);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_item(random_item());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_directed_ops();
    send_op(OP_PAINT, 0, 0, 0, 0, 24'h000000);
    send_op(OP_PAINT, 1023, 767, COORD_MAX, COORD_MAX, 24'hffffff);
    send_op(OP_READ, 0, 0, 0, 0, 24'h0);
    send_op(OP_READ, 1023, 767, 0, 0, 24'h0);
    send_op(OP_INVERT, 0, 0, 0, 0, 24'h0);
    send_op(OP_READ, 0, 0, 0, 0, 24'h0);
    send_op(OP_PAINT, 5, 3, 0, 0, 24'h123456);
    send_op(OP_GREY, 5, 3, 0, 0, 24'h0);
    send_op(OP_READ, 5, 3, 0, 0, 24'h0);
    send_op(OP_GREY, 1023, 767, 0, 0, 24'h0);
    // out of range coordinates
    send_op(OP_PAINT, 1024, 0, 0, 0, 24'h00ff00);
    send_op(OP_PAINT, 0, 768, 0, 0, 24'h00ff00);
    send_op(OP_INVERT, COORD_MAX, COORD_MAX, 0, 0, 24'h0);
    send_op(OP_READ, 1024, 767, 0, 0, 24'h0);
    send_op(OP_GREY, 0, COORD_MAX, 0, 0, 24'h0);
    // transparent key skips even when out of range
    send_op(OP_PAINT, COORD_MAX, COORD_MAX, 0, 0, TRANSPARENT_KEY);
    send_op(OP_FILL, 10, 10, 4, 3, 24'habcdef);
    send_op(OP_READ, 13, 12, 0, 0, 24'h0);
    // fill crossing the right edge keeps what it drew
    send_op(OP_FILL, 1020, 20, 8, 2, 24'h00ff00);
    send_op(OP_READ, 1023, 20, 0, 0, 24'h0);
    send_op(OP_FILL, COORD_MAX, COORD_MAX, 0, 5, 24'h0000ff);
    send_op(OP_FILL, COORD_MAX, COORD_MAX, 5, 0, 24'h0000ff);
    send_op(OP_FILL, 0, 0, COORD_MAX, COORD_MAX, TRANSPARENT_KEY);
    for (int op = OP_READ + 1; op <= OP_TOP; op++)
      send_op(3'(op), $urandom, $urandom, $urandom, $urandom, PIX_W'($urandom));
  endtask

  task automatic test_config_extremes();
    set_res(1, 1);
    send_op(OP_PAINT, 0, 0, 0, 0, 24'h654321);
    send_op(OP_READ, 0, 0, 0, 0, 24'h0);
    send_op(OP_PAINT, 1, 0, 0, 0, 24'h654321);
    send_op(OP_READ, 0, 1, 0, 0, 24'h0);
    send_op(OP_FILL, 0, 0, 2, 2, 24'h0f0f0f);
    send_op(OP_READ, 0, 0, 0, 0, 24'h0);
    // zero resolution rejects every coordinate
    set_res(0, 0);
    send_op(OP_PAINT, 0, 0, 0, 0, 24'h111111);
    send_op(OP_READ, 0, 0, 0, 0, 24'h0);
    send_op(OP_FILL, 0, 0, 1, 1, 24'h111111);
    send_op(OP_FILL, 0, 0, 0, 1, 24'h111111);
    // register values above the store saturate
    set_res(COORD_MAX, COORD_MAX);
    send_op(OP_PAINT, 1023, 767, 0, 0, 24'h808080);
    send_op(OP_READ, 1023, 767, 0, 0, 24'h0);
    send_op(OP_PAINT, 1024, 0, 0, 0, 24'h808080);
    send_op(OP_READ, 0, 768, 0, 0, 24'h0);
    set_res(int'(XRES_RST), int'(YRES_RST));
  endtask

  task automatic test_random_traffic();
    run_random(150);
    drain();
    run_random(150);
    set_res(16, 16);
    run_random(150);
    set_res(COORD_MAX, COORD_MAX);
    run_random(200);
    set_res(1, 1);
    run_random(50);
    set_res(0, $urandom_range(1, MAX_H));
    run_random(50);
    set_res($urandom_range(1, MAX_W), $urandom_range(1, MAX_H));
    run_random(150);
    set_res(int'(XRES_RST), int'(YRES_RST));
    run_random(100);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (reply_q.size() == 0) begin
        fail_count++;
        $display("%0t unexpected transaction: got status %0d pixel %06h",
                 $time, out_data.status, out_data.pixel_value);
      end else begin
        want = reply_q.pop_front();
        if (out_data.status !== want.status) begin
          fail_count++;
          $display("%0t status mismatch: expected %0d actual %0d",
                   $time, want.status, out_data.status);
        end
        if (out_data.pixel_value !== want.pixel_value) begin
          fail_count++;
          $display("%0t pixel_value mismatch: expected %06h actual %06h",
                   $time, want.pixel_value, out_data.pixel_value);
        end
      end
      stall_left = no_idle ? 0 : $urandom_range(0, 15);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    x_res = int'(XRES_RST);
    y_res = int'(YRES_RST);
    fail_count = 0;
    stall_left = 0;
    no_idle = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_ops();
    test_config_extremes();
    test_random_traffic();
    drain();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
